// File: src/sqrot_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sqrot_pkg
// Shared types and constants of the square matrix quarter-turn rotator:
// channel payloads, register map, action and turn codes, and the command
// bundle from the controller to the datapath.
// ----------------------------------------------------------------------------
package sqrot_pkg;

   // data and register widths
   localparam int DATA_W       = 32;
   localparam int MAX_SIDE_DEF = 16;
   localparam int TURNS_W      = 2;
   localparam int SIZE_W       = 5;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [SIZE_W-1:0]  SIZE_RESET  = 5'd16;
   localparam logic [TURNS_W-1:0] TURNS_RESET = 2'd0;

   // request actions
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_EMIT = 1'b1;

   // register indexes (paddr[2])
   localparam logic REG_TURNS = 1'b0;
   localparam logic REG_SIZE  = 1'b1;

   // clockwise quarter turns
   localparam logic [TURNS_W-1:0] TURN_0 = 2'd0;
   localparam logic [TURNS_W-1:0] TURN_1 = 2'd1;
   localparam logic [TURNS_W-1:0] TURN_2 = 2'd2;
   localparam logic [TURNS_W-1:0] TURN_3 = 2'd3;

   typedef struct packed {
      logic                     action;
      logic signed [DATA_W-1:0] element_in;
   } sqrot_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] element_out;
      logic                     last;
   } sqrot_rsp_type;

   // controller -> datapath commands
   typedef struct packed {
      logic clear_we;    // write zero at the sweep address
      logic div_init;    // load the position dividers
      logic div_step;    // one quotient bit per lane
      logic div_finish;  // take row and column from the dividers
      logic run;         // requests may be accepted
   } sqrot_cmd_type;

endpackage
`default_nettype wire

// File: src/sqrot_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sqrot_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// Read data holds until the next read.
// ----------------------------------------------------------------------------
module sqrot_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// File: src/sqrot_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sqrot_ctrl
// Sequencer of the rotator: clearing sweep after reset, normal running, and
// the position re-derivation pass that follows a write of the side length.
// ----------------------------------------------------------------------------
module sqrot_ctrl
   import sqrot_pkg::*;
#(
   parameter int MAX_SIDE = MAX_SIDE_DEF
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       size_wr,
   output sqrot_cmd_type                                   cmd,
   output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]            clr_addr
);

   localparam int DEPTH = MAX_SIDE * MAX_SIDE;
   localparam int CNT_W = $clog2(DEPTH);

   localparam logic [CNT_W-1:0] CLR_LAST = CNT_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(CNT_W + 1);

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_RUN   = 3'b010,
      ST_DIV   = 3'b100
   } sqrot_state_type;

   sqrot_state_type  state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (cnt_ff == CLR_LAST) begin
               state_in = ST_RUN;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_RUN: begin
            if (size_wr) begin
               state_in = ST_DIV;
               cnt_in   = '0;
            end
         end
         ST_DIV: begin
            // a new side length restarts the pass
            if (size_wr) begin
               cnt_in = '0;
            end else if (cnt_ff == DIV_LAST) begin
               state_in = ST_RUN;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         default: begin
            state_in = ST_CLEAR;
            cnt_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // commands
   always_comb begin
      cmd.clear_we   = (state_ff == ST_CLEAR);
      cmd.run        = (state_ff == ST_RUN);
      cmd.div_init   = (state_ff == ST_DIV) && (cnt_ff == '0);
      cmd.div_finish = (state_ff == ST_DIV) && (cnt_ff == DIV_LAST);
      cmd.div_step   = (state_ff == ST_DIV) && (cnt_ff != '0) && (cnt_ff != DIV_LAST);
   end

   assign clr_addr = cnt_ff;

endmodule
`default_nettype wire

// File: src/sqrot_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sqrot_dpath
// Datapath of the rotator: load and emit row/column counters, the turn
// address remap, the element store, the read/output stages and two
// bit-serial dividers that turn linear positions into row and column.
// ----------------------------------------------------------------------------
module sqrot_dpath
   import sqrot_pkg::*;
#(
   parameter int MAX_SIDE = MAX_SIDE_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire sqrot_cmd_type                       cmd,
   input  wire logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0] clr_addr,
   input  wire logic [TURNS_W-1:0]                  quarter_turns,
   input  wire logic [SIZE_W-1:0]                   matrix_size,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire sqrot_req_type                       req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output sqrot_rsp_type                            rsp_data
);

   localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
   localparam int POS_W  = $clog2(DEPTH);
   localparam int RC_W   = $clog2(MAX_SIDE);
   localparam int SIDE_W = $clog2(MAX_SIDE + 1);

   localparam logic [POS_W-1:0] SIDE_P = POS_W'(MAX_SIDE);

   // lane 0 tracks the load position, lane 1 the emit position
   localparam int LANE_LD = 0;
   localparam int LANE_EM = 1;

   logic [SIDE_W-1:0] side_n;
   logic [RC_W-1:0]   nm1;

   logic [RC_W-1:0]  ld_r_ff, ld_r_in, ld_c_ff, ld_c_in;
   logic [RC_W-1:0]  em_r_ff, em_r_in, em_c_ff, em_c_in;
   logic [POS_W-1:0] ld_p_ff, ld_p_in, em_p_ff, em_p_in;
   logic             ld_over_ff, ld_over_in, em_over_ff, em_over_in;

   logic [POS_W-1:0]  pos_cur [2];
   logic [POS_W-1:0]  quo_ff  [2];
   logic [POS_W-1:0]  quo_in  [2];
   logic [SIDE_W-1:0] rem_ff  [2];
   logic [SIDE_W-1:0] rem_in  [2];
   logic [SIDE_W:0]   rem_sh  [2];
   logic [SIDE_W:0]   rem_dif [2];
   logic              quo_big [2];

   logic              drain, emit_ok, accept, ld_acc, em_acc;
   logic              ld_last, em_last;
   logic [RC_W-1:0]   src_r, src_c;
   logic [POS_W-1:0]  ld_addr, em_addr;

   logic              ram_we;
   logic [POS_W-1:0]  ram_waddr;
   logic [DATA_W-1:0] ram_wdata;
   logic [DATA_W-1:0] ram_rdata;

   logic              rd_pend_ff, rd_pend_in;
   logic              rd_last_ff, rd_last_in;
   logic              out_valid_ff, out_valid_in;
   sqrot_rsp_type     out_data_ff, out_data_in;

   // side length in use: zero acts as one, clamp to the store size
   always_comb begin
      if (matrix_size == '0) begin
         side_n = SIDE_W'(1);
      end else if (32'(matrix_size) > 32'(MAX_SIDE)) begin
         side_n = SIDE_W'(MAX_SIDE);
      end else begin
         side_n = SIDE_W'(matrix_size);
      end
   end

   assign nm1 = RC_W'(side_n - SIDE_W'(1));

   // handshake: a request needs the read stage free or draining
   assign drain     = !out_valid_ff || !rsp_stall;
   assign emit_ok   = !rd_pend_ff || drain;
   assign req_stall = !cmd.run || !emit_ok;
   assign accept    = req_valid && !req_stall;
   assign ld_acc    = accept && (req_data.action == ACT_LOAD);
   assign em_acc    = accept && (req_data.action == ACT_EMIT);

   assign ld_last = (ld_r_ff == nm1) && (ld_c_ff == nm1);
   assign em_last = (em_r_ff == nm1) && (em_c_ff == nm1);

   // source coordinates of the turned element
   always_comb begin
      unique case (quarter_turns)
         TURN_0: begin
            src_r = em_r_ff;
            src_c = em_c_ff;
         end
         TURN_1: begin
            src_r = nm1 - em_c_ff;
            src_c = em_r_ff;
         end
         TURN_2: begin
            src_r = nm1 - em_r_ff;
            src_c = nm1 - em_c_ff;
         end
         TURN_3: begin
            src_r = em_c_ff;
            src_c = nm1 - em_r_ff;
         end
         default: begin
            src_r = em_r_ff;
            src_c = em_c_ff;
         end
      endcase
   end

   assign ld_addr = POS_W'(ld_r_ff) * SIDE_P + POS_W'(ld_c_ff);
   assign em_addr = POS_W'(src_r) * SIDE_P + POS_W'(src_c);

   // position dividers, one quotient bit per step
   assign pos_cur[LANE_LD] = ld_p_ff;
   assign pos_cur[LANE_EM] = em_p_ff;

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         rem_sh[i]  = {rem_ff[i], quo_ff[i][POS_W-1]};
         rem_dif[i] = rem_sh[i] - {1'b0, side_n};
         quo_big[i] = (quo_ff[i] >= POS_W'(side_n));
         quo_in[i]  = quo_ff[i];
         rem_in[i]  = rem_ff[i];
         if (cmd.div_init) begin
            quo_in[i] = pos_cur[i];
            rem_in[i] = '0;
         end else if (cmd.div_step) begin
            if (rem_sh[i] >= {1'b0, side_n}) begin
               rem_in[i] = rem_dif[i][SIDE_W-1:0];
               quo_in[i] = {quo_ff[i][POS_W-2:0], 1'b1};
            end else begin
               rem_in[i] = rem_sh[i][SIDE_W-1:0];
               quo_in[i] = {quo_ff[i][POS_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 2; i++) begin
         quo_ff[i] <= quo_in[i];
         rem_ff[i] <= rem_in[i];
      end
   end

   // load position
   always_comb begin
      ld_r_in    = ld_r_ff;
      ld_c_in    = ld_c_ff;
      ld_p_in    = ld_p_ff;
      ld_over_in = ld_over_ff;
      if (cmd.div_finish) begin
         // position past the new matrix acts as zero; the linear count is
         // kept so a later side change sees it unchanged
         ld_over_in = quo_big[LANE_LD];
         if (quo_big[LANE_LD]) begin
            ld_r_in = '0;
            ld_c_in = '0;
         end else begin
            ld_r_in = RC_W'(quo_ff[LANE_LD]);
            ld_c_in = RC_W'(rem_ff[LANE_LD]);
         end
      end else if (ld_acc) begin
         if (ld_c_ff == nm1) begin
            ld_c_in = '0;
            ld_r_in = (ld_r_ff == nm1) ? '0 : ld_r_ff + RC_W'(1);
         end else begin
            ld_c_in = ld_c_ff + RC_W'(1);
         end
         ld_over_in = 1'b0;
         if (ld_last) begin
            ld_p_in = '0;
         end else if (ld_over_ff) begin
            ld_p_in = POS_W'(1);
         end else begin
            ld_p_in = ld_p_ff + POS_W'(1);
         end
      end
   end

   // emit position
   always_comb begin
      em_r_in    = em_r_ff;
      em_c_in    = em_c_ff;
      em_p_in    = em_p_ff;
      em_over_in = em_over_ff;
      if (cmd.div_finish) begin
         em_over_in = quo_big[LANE_EM];
         if (quo_big[LANE_EM]) begin
            em_r_in = '0;
            em_c_in = '0;
         end else begin
            em_r_in = RC_W'(quo_ff[LANE_EM]);
            em_c_in = RC_W'(rem_ff[LANE_EM]);
         end
      end else if (em_acc) begin
         if (em_c_ff == nm1) begin
            em_c_in = '0;
            em_r_in = (em_r_ff == nm1) ? '0 : em_r_ff + RC_W'(1);
         end else begin
            em_c_in = em_c_ff + RC_W'(1);
         end
         em_over_in = 1'b0;
         if (em_last) begin
            em_p_in = '0;
         end else if (em_over_ff) begin
            em_p_in = POS_W'(1);
         end else begin
            em_p_in = em_p_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ld_r_ff    <= '0;
         ld_c_ff    <= '0;
         ld_p_ff    <= '0;
         ld_over_ff <= 1'b0;
         em_r_ff    <= '0;
         em_c_ff    <= '0;
         em_p_ff    <= '0;
         em_over_ff <= 1'b0;
      end else begin
         ld_r_ff    <= ld_r_in;
         ld_c_ff    <= ld_c_in;
         ld_p_ff    <= ld_p_in;
         ld_over_ff <= ld_over_in;
         em_r_ff    <= em_r_in;
         em_c_ff    <= em_c_in;
         em_p_ff    <= em_p_in;
         em_over_ff <= em_over_in;
      end
   end

   // element store: clearing sweep or load writes, emit reads
   assign ram_we    = cmd.clear_we || ld_acc;
   assign ram_waddr = cmd.clear_we ? clr_addr : ld_addr;
   assign ram_wdata = cmd.clear_we ? '0 : DATA_W'(req_data.element_in);

   sqrot_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (em_acc),
      .raddr (em_addr),
      .rdata (ram_rdata)
   );

   // read stage and output register
   always_comb begin
      rd_pend_in   = rd_pend_ff;
      rd_last_in   = rd_last_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (drain) begin
         out_valid_in = rd_pend_ff;
         rd_pend_in   = 1'b0;
         if (rd_pend_ff) begin
            out_data_in.element_out = $signed(ram_rdata);
            out_data_in.last        = rd_last_ff;
         end
      end
      if (em_acc) begin
         rd_pend_in = 1'b1;
         rd_last_in = em_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         rd_pend_ff   <= rd_pend_in;
         out_valid_ff <= out_valid_in;
      end
      rd_last_ff  <= rd_last_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
`default_nettype wire

// File: src/square_matrix_quarter_turn_rotator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// square_matrix_quarter_turn_rotator
// Stores an n by n matrix of signed 32-bit words loaded in row-major order
// and streams it back turned clockwise by 0 to 3 quarter turns.
// ----------------------------------------------------------------------------
// Loads and emits are each accepted at one request per clock: every request
// is a single access to the element store at a remapped address. An emit's
// element leaves through a registered store read and an output register;
// requests keep flowing while a result waits, and stall once both the read
// stage and the output register are occupied. After reset the store's
// MAX_SIDE*MAX_SIDE words (256 at the default) are swept to zero, one word
// a cycle, with requests stalled. A write of matrix_size re-derives the row
// and column of both positions by bit-serial dividers, stalling requests
// while they run. quarter_turns takes effect at once.
// ----------------------------------------------------------------------------
module square_matrix_quarter_turn_rotator
   import sqrot_pkg::*;
#(
   parameter int MAX_SIDE = MAX_SIDE_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire sqrot_req_type         req_data,
   // result channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output sqrot_rsp_type              rsp_data,
   // configuration port
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   logic                                 csr_wr;
   logic                                 size_wr;
   logic [TURNS_W-1:0]                   turns_ff, turns_in;
   logic [SIZE_W-1:0]                    size_ff, size_in;
   sqrot_cmd_type                        cmd;
   logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0] clr_addr;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign size_wr    = csr_wr && (csr_paddr[2] == REG_SIZE);

   always_comb begin
      turns_in = turns_ff;
      size_in  = size_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_TURNS: turns_in = csr_pwdata[TURNS_W-1:0];
            REG_SIZE:  size_in  = csr_pwdata[SIZE_W-1:0];
            default:   turns_in = turns_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         turns_ff <= TURNS_RESET;
         size_ff  <= SIZE_RESET;
      end else begin
         turns_ff <= turns_in;
         size_ff  <= size_in;
      end
   end

   // register read back
   always_comb begin
      unique case (csr_paddr[2])
         REG_TURNS: csr_prdata = CSR_DATA_W'(turns_ff);
         REG_SIZE:  csr_prdata = CSR_DATA_W'(size_ff);
         default:   csr_prdata = '0;
      endcase
   end

   sqrot_ctrl #(
      .MAX_SIDE (MAX_SIDE)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .size_wr  (size_wr),
      .cmd      (cmd),
      .clr_addr (clr_addr)
   );

   sqrot_dpath #(
      .MAX_SIDE (MAX_SIDE)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .clr_addr      (clr_addr),
      .quarter_turns (turns_ff),
      .matrix_size   (size_ff),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data)
   );

   // no request may slip in while the store is being swept
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_we |-> !(req_valid && !req_stall))
      else $error("request accepted during clearing sweep");

   // the clearing sweep holds off requests right after reset
   a_stall_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> req_stall)
      else $error("requests not stalled after reset");

   // a side length write starts the re-derivation pass
   a_stall_after_size: assert property (@(posedge clock) disable iff (reset)
      size_wr |=> req_stall)
      else $error("requests not stalled after side length write");

endmodule
`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the square matrix quarter-turn rotator. Requests
// load and emit matrix elements under changing side and turn settings; a
// scoreboard keeps its own copy of the element store and positions, predicts
// every emitted element with its last flag, and compares results in order.
// ----------------------------------------------------------------------------
module tb;
   import sqrot_pkg::*;

   localparam int MAX_SIDE         = MAX_SIDE_DEF;
   localparam int SETTLE_CYCLES    = 8;
   localparam int HOLD_CYCLES      = 150;
   localparam int QUIET_LIMIT      = 4000;
   localparam int ITEMS_PER_PHASE  = 440;

   // Tracks the rotator state and the elements it owes.
   class rotation_scoreboard;
      logic [DATA_W-1:0]  element_store [MAX_SIDE*MAX_SIDE];
      int unsigned        load_pos;
      int unsigned        emit_pos;
      logic [TURNS_W-1:0] turns;
      logic [SIZE_W-1:0]  side_reg;
      sqrot_rsp_type      owed_elements [$];
      int unsigned        mismatches;

      function new();
         foreach (element_store[i]) element_store[i] = '0;
         load_pos   = 0;
         emit_pos   = 0;
         turns      = TURNS_RESET;
         side_reg   = SIZE_RESET;
         mismatches = 0;
      endfunction

      function void note_request(sqrot_req_type req);
         int unsigned   n, total, p, r, c, sr, sc;
         sqrot_rsp_type rsp;
         n = side_reg;
         if (n < 1) n = 1;
         if (n > MAX_SIDE) n = MAX_SIDE;
         total = n * n;
         if (req.action == ACT_LOAD) begin
            p = (load_pos >= total) ? 0 : load_pos;
            r = p / n;
            c = p % n;
            element_store[r*MAX_SIDE + c] = req.element_in;
            load_pos = (p + 1 >= total) ? 0 : p + 1;
         end else begin
            p = (emit_pos >= total) ? 0 : emit_pos;
            r = p / n;
            c = p % n;
            case (turns)
               TURN_0: begin sr = r;         sc = c;         end
               TURN_1: begin sr = n - 1 - c; sc = r;         end
               TURN_2: begin sr = n - 1 - r; sc = n - 1 - c; end
               default: begin sr = c;        sc = n - 1 - r; end
            endcase
            rsp.element_out = element_store[sr*MAX_SIDE + sc];
            rsp.last        = (p == total - 1);
            owed_elements   = {owed_elements, rsp};
            emit_pos = (p + 1 >= total) ? 0 : p + 1;
         end
      endfunction

      function void check_result(sqrot_rsp_type got);
         sqrot_rsp_type want;
         if (owed_elements.size() == 0) begin
            $error("unexpected result: element_out %0d last %0b", got.element_out, got.last);
            mismatches++;
            return;
         end
         want = owed_elements.pop_front();
         if (got.element_out !== want.element_out) begin
            $error("element_out: expected %0d, got %0d", want.element_out, got.element_out);
            mismatches++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            mismatches++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   sqrot_req_type         req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   sqrot_rsp_type         rsp_data;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   rotation_scoreboard sb = new();
   int unsigned requests_sent = 0;
   int unsigned csr_errors    = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   bit          hold_request  = 1'b0;
   int unsigned hold_left     = 0;
   int unsigned quiet_cycles  = 0;

   square_matrix_quarter_turn_rotator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   // result side: random stall, or a long hold-off when asked
   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[square_matrix_quarter_turn_rotator] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // element values biased toward the extremes
   function automatic logic [DATA_W-1:0] pick_element();
      case ($urandom_range(9))
         0: pick_element = 32'h8000_0000;
         1: pick_element = 32'h7fff_ffff;
         2: pick_element = '0;
         3: pick_element = '1;
         default: pick_element = $urandom;
      endcase
   endfunction

   task automatic send_request(input logic action, input logic [DATA_W-1:0] value);
      sqrot_req_type item;
      item.action     = action;
      item.element_in = value;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(item);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic send_loads(input int unsigned count);
      repeat (count) send_request(ACT_LOAD, pick_element());
   endtask

   task automatic send_emits(input int unsigned count);
      repeat (count) send_request(ACT_EMIT, $urandom);
   endtask

   // stop requesting until every owed element is back and the pipe is empty
   task automatic quiesce();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.owed_elements.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // one APB transfer: setup, access, then idle
   task automatic csr_transfer(input logic write, input logic [CSR_ADDR_W-1:0] addr,
                               input logic [CSR_DATA_W-1:0] wdata,
                               output logic [CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // write a register, read it back, and track it in the scoreboard
   task automatic write_register(input logic reg_index, input logic [CSR_DATA_W-1:0] value);
      logic [CSR_ADDR_W-1:0] addr;
      logic [CSR_DATA_W-1:0] rdata;
      logic [CSR_DATA_W-1:0] stored;
      addr = {reg_index, 2'b00};
      if (reg_index == REG_TURNS) stored = CSR_DATA_W'(value[TURNS_W-1:0]);
      else stored = CSR_DATA_W'(value[SIZE_W-1:0]);
      csr_transfer(1'b1, addr, value, rdata);
      csr_transfer(1'b0, addr, '0, rdata);
      if (rdata !== stored) begin
         $error("register %0d readback: expected %0d, got %0d", reg_index, stored, rdata);
         csr_errors++;
      end
      if (reg_index == REG_TURNS) sb.turns = stored[TURNS_W-1:0];
      else sb.side_reg = stored[SIZE_W-1:0];
   endtask

   task automatic configure(input logic [TURNS_W-1:0] turns, input logic [SIZE_W-1:0] side);
      quiesce();
      write_register(REG_TURNS, CSR_DATA_W'(turns));
      write_register(REG_SIZE, CSR_DATA_W'(side));
   endtask

   // one random stretch: mostly full load/emit passes, some noise
   task automatic random_segment();
      int unsigned       k, n, total, short_by;
      logic [SIZE_W-1:0] side;
      k = $urandom_range(99);
      if (k < 4) side = '0;
      else if (k < 8) side = SIZE_W'($urandom_range(MAX_SIDE + 1, 31));
      else if (k < 16) side = SIZE_W'($urandom_range(6, 8));
      else side = SIZE_W'($urandom_range(1, 5));
      configure(TURNS_W'($urandom_range(3)), side);
      n = (side < 1) ? 1 : ((side > MAX_SIDE) ? MAX_SIDE : side);
      total = n * n;
      if (n >= MAX_SIDE || $urandom_range(4) == 0) begin
         // noise: random mix of loads and emits
         repeat ($urandom_range(5, 40)) begin
            if ($urandom_range(1)) send_request(ACT_EMIT, $urandom);
            else send_request(ACT_LOAD, pick_element());
         end
      end else begin
         // full pass, sometimes cut short
         short_by = ($urandom_range(4) == 0) ? $urandom_range(1, n) : 0;
         send_loads(total - short_by);
         send_emits(total);
         if ($urandom_range(1)) begin
            quiesce();
            write_register(REG_TURNS, $urandom_range(3));
            send_emits(total);
         end
      end
   endtask

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_stall   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // let the store clearing sweep finish
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);

      send_idle_pct  = 37;
      recv_stall_pct = 58;

      // directed: emit before any load returns cleared words
      send_emits(2);
      // 2x2, one turn, extreme values; emit position starts mid-matrix
      configure(TURN_1, 5'd2);
      send_request(ACT_LOAD, 32'h8000_0000);
      send_request(ACT_LOAD, 32'h7fff_ffff);
      send_request(ACT_LOAD, 32'hffff_ffff);
      send_request(ACT_LOAD, 32'h0000_0000);
      send_emits(4);
      configure(TURN_2, 5'd2);
      send_emits(4);
      // zero side acts as one
      configure(TURN_3, 5'd0);
      send_request(ACT_LOAD, 32'h5a5a_a5a5);
      send_emits(2);
      // oversize side acts as the maximum
      configure(TURN_2, 5'd31);
      send_emits(2);
      send_request(ACT_LOAD, 32'h0000_0001);
      // shrink below the positions so both restart
      configure(TURN_0, 5'd1);
      send_emits(2);

      // random phases with changing idle patterns
      for (int phase = 0; phase < 3; phase++) begin
         int unsigned target;
         send_idle_pct  = (phase == 0) ? 37 : ((phase == 1) ? 58 : 0);
         recv_stall_pct = (phase == 0) ? 58 : ((phase == 1) ? 37 : 0);
         target = requests_sent + ITEMS_PER_PHASE;
         if (phase == 2) begin
            // full-size pass with a long result hold-off to back up the pipe
            configure(TURNS_W'($urandom_range(3)), SIZE_W'(MAX_SIDE));
            send_loads(MAX_SIDE * MAX_SIDE);
            hold_request = 1'b1;
            send_emits(MAX_SIDE * MAX_SIDE);
         end
         while (requests_sent < target) random_segment();
      end

      quiesce();
      if (sb.mismatches == 0 && csr_errors == 0) begin
         $display("[square_matrix_quarter_turn_rotator] OK");
      end else begin
         $display("[square_matrix_quarter_turn_rotator] ERROR");
      end
      $finish;
   end

endmodule
